@@ design/clps_pkg.sv @@
// Shared types and constants for the character display sequencer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package clps_pkg;

	localparam int CFG_W = 20;
	localparam int COL_W = 7;
	localparam int IDX_W = 3;

	// Offered command codes.
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_CHAR   = 2'd1;
	localparam logic [1:0] CMD_INIT   = 2'd2;
	localparam logic [1:0] CMD_DEINIT = 2'd3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ENABLE_TICKS  = 3'd0;
	localparam logic [IDX_W-1:0] REG_READ_SETTLE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_BUSY_SETTLE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_COMMAND_WAIT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLEAR_WAIT    = 3'd4;
	localparam logic [IDX_W-1:0] REG_WRAP_COLUMN   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] RST_ENABLE_TICKS = 20'd1;
	localparam logic [CFG_W-1:0] RST_READ_SETTLE  = 20'd4;
	localparam logic [CFG_W-1:0] RST_BUSY_SETTLE  = 20'd32;
	localparam logic [CFG_W-1:0] RST_COMMAND_WAIT = 20'd200;
	localparam logic [CFG_W-1:0] RST_CLEAR_WAIT   = 20'd8000;
	localparam logic [COL_W-1:0] RST_WRAP_COLUMN  = 7'd20;

	// Controller instruction bytes.
	localparam logic [7:0] BYTE_FUNC_SET    = 8'h38;
	localparam logic [7:0] BYTE_DISPLAY_ON  = 8'h0E;
	localparam logic [7:0] BYTE_CLEAR       = 8'h01;
	localparam logic [7:0] BYTE_ENTRY_MODE  = 8'h06;
	localparam logic [7:0] BYTE_SET_DDRAM   = 8'h80;
	localparam logic [7:0] BYTE_ROW_TWO     = 8'h40;

	localparam logic [COL_W-1:0] COL_MAX = 7'd127;

	// Job step numbers. Steps 0 and 2 are busy polls, and step 4 also in the init job.
	localparam logic [2:0] STEP_POLL_FIRST = 3'd0;
	localparam logic [2:0] STEP_CHAR_ROW   = 3'd1;
	localparam logic [2:0] STEP_POLL_MID   = 3'd2;
	localparam logic [2:0] STEP_CHAR_DATA  = 3'd3;
	localparam logic [2:0] STEP_INIT_FUNC  = 3'd1;
	localparam logic [2:0] STEP_INIT_DISP  = 3'd3;
	localparam logic [2:0] STEP_INIT_POLL  = 3'd4;
	localparam logic [2:0] STEP_INIT_CLEAR = 3'd5;
	localparam logic [2:0] STEP_INIT_ENTRY = 3'd6;

	typedef struct packed {
		logic [CFG_W-1:0] enable_ticks;
		logic [CFG_W-1:0] read_settle_ticks;
		logic [CFG_W-1:0] busy_settle_ticks;
		logic [CFG_W-1:0] command_wait_ticks;
		logic [CFG_W-1:0] clear_wait_ticks;
		logic [COL_W-1:0] wrap_column;
	} clps_cfg_t;

	typedef struct packed {
		logic       enable_pin;
		logic       register_select;
		logic       read_not_write;
		logic [7:0] bus_out;
		logic       bus_drive;
		logic       accepted;
		logic       ready_res;
		logic       initialized;
	} clps_result_t;

endpackage

@@ design/clps_cfg.sv @@
// Configuration register file of the character display sequencer.
// Depends on clps_pkg for register indexes, reset values and clps_cfg_t.
`timescale 1ns / 1ps

module clps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [clps_pkg::IDX_W-1:0]  wr_index,
	input  logic [clps_pkg::CFG_W-1:0]  wr_data,
	output clps_pkg::clps_cfg_t         cfg
);
	import clps_pkg::*;

	clps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_ticks       <= RST_ENABLE_TICKS;
			cfg_q.read_settle_ticks  <= RST_READ_SETTLE;
			cfg_q.busy_settle_ticks  <= RST_BUSY_SETTLE;
			cfg_q.command_wait_ticks <= RST_COMMAND_WAIT;
			cfg_q.clear_wait_ticks   <= RST_CLEAR_WAIT;
			cfg_q.wrap_column        <= RST_WRAP_COLUMN;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENABLE_TICKS: cfg_q.enable_ticks       <= wr_data;
				REG_READ_SETTLE:  cfg_q.read_settle_ticks  <= wr_data;
				REG_BUSY_SETTLE:  cfg_q.busy_settle_ticks  <= wr_data;
				REG_COMMAND_WAIT: cfg_q.command_wait_ticks <= wr_data;
				REG_CLEAR_WAIT:   cfg_q.clear_wait_ticks   <= wr_data;
				REG_WRAP_COLUMN:  cfg_q.wrap_column        <= wr_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/clps_seq.sv @@
// Tick sequencer: phase, step, timer and column state, and the pin levels for one tick.
// Depends on clps_pkg for codes, instruction bytes and the cfg/result structs.
`timescale 1ns / 1ps

module clps_seq #(
	parameter int TW = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [1:0]           command,
	input  logic [7:0]           char_code,
	input  logic                 first_of_string,
	input  logic [7:0]           bus_in,
	input  clps_pkg::clps_cfg_t  cfg,
	output clps_pkg::clps_result_t res
);
	import clps_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POLL_HI,
		PH_POLL_LO,
		PH_SETTLE,
		PH_WR_SETUP,
		PH_WR_HIGH,
		PH_WR_HOLD,
		PH_WAIT
	} phase_t;

	typedef struct packed {
		phase_t        ph;
		logic [2:0]    step;
		logic [TW-1:0] cnt;
		logic          due;
		logic          done;
	} st_t;

	st_t              cur_q, nxt;
	logic             job_q, job_n;
	logic [COL_W-1:0] col_q, col_n, col_base;
	logic [7:0]       pend_q, pend_n;
	logic [TW-1:0]    rs_t, en_t, bs_t, cw_t, clr_t;
	clps_result_t     r;

	// Timer loads, masked to the counter; poll and write phases last at least one tick.
	always_comb begin
		rs_t  = TW'(cfg.read_settle_ticks);
		en_t  = TW'(cfg.enable_ticks);
		bs_t  = TW'(cfg.busy_settle_ticks);
		cw_t  = TW'(cfg.command_wait_ticks);
		clr_t = TW'(cfg.clear_wait_ticks);
		if (rs_t == '0) rs_t = TW'(1);
		if (en_t == '0) en_t = TW'(1);
	end

	function automatic st_t begin_step(input st_t s, input logic [2:0] n, input logic job,
		input logic [TW-1:0] rs, input logic [TW-1:0] en);
		st_t  o;
		logic poll;
		o      = s;
		o.step = n;
		// A character without a row change skips straight to its data write.
		if (job && n == STEP_CHAR_ROW && !s.due) o.step = STEP_CHAR_DATA;
		if (job) poll = (o.step == STEP_POLL_FIRST) || (o.step == STEP_POLL_MID);
		else     poll = (o.step == STEP_POLL_FIRST) || (o.step == STEP_POLL_MID) ||
		                (o.step == STEP_INIT_POLL);
		if (poll) begin
			o.ph  = PH_POLL_HI;
			o.cnt = rs;
		end else begin
			o.ph  = PH_WR_SETUP;
			o.cnt = en;
		end
		return o;
	endfunction

	function automatic st_t finish_step(input st_t s, input logic job,
		input logic [TW-1:0] rs, input logic [TW-1:0] en);
		st_t o;
		o = s;
		if (job && s.step >= STEP_CHAR_DATA) begin
			o.ph  = PH_IDLE;
			o.cnt = '0;
		end else if (!job && s.step >= STEP_INIT_ENTRY) begin
			o.ph   = PH_IDLE;
			o.cnt  = '0;
			o.done = 1'b1;
		end else begin
			if (job && s.step == STEP_CHAR_ROW) o.due = 1'b0;
			o = begin_step(o, s.step + 3'd1, job, rs, en);
		end
		return o;
	endfunction

	function automatic st_t enter_wait(input st_t s, input logic [TW-1:0] ticks,
		input phase_t ph, input logic job, input logic [TW-1:0] rs, input logic [TW-1:0] en);
		st_t o;
		o = s;
		if (ticks == '0) begin
			o = finish_step(s, job, rs, en);
		end else begin
			o.ph  = ph;
			o.cnt = ticks;
		end
		return o;
	endfunction

	function automatic logic [7:0] step_byte(input logic job, input logic [2:0] step,
		input logic [7:0] pend);
		logic [7:0] b;
		if (job) begin
			b = (step == STEP_CHAR_DATA) ? pend : (BYTE_SET_DDRAM | BYTE_ROW_TWO);
		end else begin
			case (step)
				STEP_INIT_FUNC:  b = BYTE_FUNC_SET;
				STEP_INIT_DISP:  b = BYTE_DISPLAY_ON;
				STEP_INIT_CLEAR: b = BYTE_CLEAR;
				default:         b = BYTE_ENTRY_MODE;
			endcase
		end
		return b;
	endfunction

	always_comb begin
		nxt      = cur_q;
		job_n    = job_q;
		col_n    = col_q;
		pend_n   = pend_q;
		col_base = first_of_string ? '0 : col_q;
		r        = '0;

		// Command intake, only from idle.
		if (cur_q.ph == PH_IDLE && command != CMD_NONE) begin
			r.accepted = 1'b1;
			unique case (command)
				CMD_CHAR: begin
					nxt.due = (cfg.wrap_column != '0) && (col_base == cfg.wrap_column);
					col_n   = (col_base < COL_MAX) ? col_base + COL_W'(1) : col_base;
					pend_n  = char_code;
					job_n   = 1'b1;
					nxt     = begin_step(nxt, STEP_POLL_FIRST, 1'b1, rs_t, en_t);
				end
				CMD_INIT: begin
					if (!cur_q.done) begin
						job_n = 1'b0;
						nxt   = begin_step(nxt, STEP_POLL_FIRST, 1'b0, rs_t, en_t);
					end
				end
				CMD_DEINIT: nxt.done = 1'b0;
				default: ;
			endcase
		end

		// Pin levels for this tick, then the timer advance.
		r.bus_drive = nxt.done;
		if (nxt.ph != PH_IDLE) begin
			r.bus_drive = 1'b1;
			case (nxt.ph) inside
				PH_POLL_HI: begin
					r.enable_pin     = 1'b1;
					r.read_not_write = 1'b1;
					r.bus_drive      = 1'b0;
				end
				PH_POLL_LO: begin
					r.read_not_write = 1'b1;
					r.bus_drive      = 1'b0;
				end
				PH_WR_SETUP, PH_WR_HIGH, PH_WR_HOLD: begin
					r.enable_pin      = (nxt.ph == PH_WR_HIGH);
					r.register_select = job_n && (nxt.step == STEP_CHAR_DATA);
					r.bus_out         = step_byte(job_n, nxt.step, pend_n);
				end
				default: ;
			endcase

			if (nxt.cnt > TW'(1)) begin
				nxt.cnt = nxt.cnt - TW'(1);
			end else begin
				case (nxt.ph)
					PH_POLL_HI: begin
						if (bus_in[7]) begin
							nxt.ph  = PH_POLL_LO;
							nxt.cnt = TW'(1);
						end else begin
							nxt = enter_wait(nxt, bs_t, PH_SETTLE, job_n, rs_t, en_t);
						end
					end
					PH_POLL_LO: begin
						nxt.ph  = PH_POLL_HI;
						nxt.cnt = rs_t;
					end
					PH_WR_SETUP: begin
						nxt.ph  = PH_WR_HIGH;
						nxt.cnt = en_t;
					end
					PH_WR_HIGH: begin
						nxt.ph  = PH_WR_HOLD;
						nxt.cnt = en_t;
					end
					PH_WR_HOLD: begin
						nxt = enter_wait(nxt,
							(!job_n && nxt.step == STEP_INIT_CLEAR) ? clr_t : cw_t,
							PH_WAIT, job_n, rs_t, en_t);
					end
					default: nxt = finish_step(nxt, job_n, rs_t, en_t);
				endcase
			end
		end

		r.ready_res   = (nxt.ph == PH_IDLE);
		r.initialized = nxt.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.ph   <= PH_IDLE;
			cur_q.step <= '0;
			cur_q.cnt  <= '0;
			cur_q.due  <= 1'b0;
			cur_q.done <= 1'b0;
			job_q      <= 1'b0;
			col_q      <= '0;
			pend_q     <= '0;
		end else if (step_en) begin
			cur_q  <= nxt;
			job_q  <= job_n;
			col_q  <= col_n;
			pend_q <= pend_n;
		end
	end

	assign res = r;

endmodule

@@ design/char_lcd_parallel_sequencer_core.sv @@
// Character display sequencer, top level: one request is one timing tick of the pins.
// The result of a request is registered and presented in the cycle after it is accepted.
// One request per cycle while out_ready is high; the tick logic is a single registered pass.
// Reset (arst_n low, asynchronous): idle, not initialised, column count zero,
// configuration at its defaults, no result pending.
`timescale 1ns / 1ps

module char_lcd_parallel_sequencer_core #(
	parameter int TIMER_WIDTH = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [clps_pkg::IDX_W-1:0]  cfg_index,
	input  logic [clps_pkg::CFG_W-1:0]  cfg_data,
	// Request channel: one tick of the sequencer per request.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [7:0]                  char_code,
	input  logic                        first_of_string,
	input  logic [7:0]                  bus_in,
	// Result channel: the pin levels and status after that tick.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        enable_pin,
	output logic                        register_select,
	output logic                        read_not_write,
	output logic [7:0]                  bus_out,
	output logic                        bus_drive,
	output logic                        accepted,
	output logic                        ready_res,
	output logic                        initialized
);
	import clps_pkg::*;

	clps_cfg_t    cfg;
	clps_result_t res;
	clps_result_t res_q;
	logic         out_valid_q;
	logic         take;

	// Configuration must be written only while the sequencer is idle (the user's
	// duty; the block does not enforce it), so the port can always take a write.
	assign cfg_ready = 1'b1;

	clps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A request is taken whenever the result register is empty or is being
	// drained in the same cycle, so with out_ready high a stream runs one request a cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// The sequencer state only moves on an accepted request; every request
	// yields exactly one result.
	clps_seq #(
		.TW (TIMER_WIDTH)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (take),
		.command         (command),
		.char_code       (char_code),
		.first_of_string (first_of_string),
		.bus_in          (bus_in),
		.cfg             (cfg),
		.res             (res)
	);

	// Result register. The payload needs no reset; only the valid flag does.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign enable_pin      = res_q.enable_pin;
	assign register_select = res_q.register_select;
	assign read_not_write  = res_q.read_not_write;
	assign bus_out         = res_q.bus_out;
	assign bus_drive       = res_q.bus_drive;
	assign accepted        = res_q.accepted;
	assign ready_res       = res_q.ready_res;
	assign initialized     = res_q.initialized;

endmodule
